[rtl/ilp_pkg.sv]
// ilp_pkg: shared types, character codes and range tables for the
// integer literal parser. No dependencies.

package ilp_pkg;

	typedef enum logic [2:0] {
		PH_FRESH  = 3'd0,
		PH_SIGN   = 3'd1,
		PH_ZERO   = 3'd2,
		PH_XPFX   = 3'd3,
		PH_DIGITS = 3'd4,
		PH_BAD    = 3'd5,
		PH_WS     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		W_NONE = 3'd0,
		W_8    = 3'd1,
		W_16   = 3'd2,
		W_32   = 3'd3,
		W_64   = 3'd4
	} width_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	// digit value; NO_DIGIT for anything that is not a digit in any radix
	localparam logic [4:0] NO_DIGIT = 5'd31;

	localparam logic [63:0] SMAX8  = 64'h0000_0000_0000_007f;
	localparam logic [63:0] SMAX16 = 64'h0000_0000_0000_7fff;
	localparam logic [63:0] SMAX32 = 64'h0000_0000_7fff_ffff;
	localparam logic [63:0] SMAX64 = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] UMAX8  = 64'h0000_0000_0000_00ff;
	localparam logic [63:0] UMAX16 = 64'h0000_0000_0000_ffff;
	localparam logic [63:0] UMAX32 = 64'h0000_0000_ffff_ffff;
	localparam logic [63:0] UMAX64 = 64'hffff_ffff_ffff_ffff;

	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [4:0] d;
		d = NO_DIGIT;
		if (c >= CH_0 && c <= CH_9) begin
			d = 5'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = 5'(c - CH_LA) + 5'd10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = 5'(c - CH_UA) + 5'd10;
		end
		return d;
	endfunction

	function automatic logic [4:0] radix_of(input radix_t r);
		logic [4:0] v;
		case (r)
			RX_OCT:  v = 5'd8;
			RX_HEX:  v = 5'd16;
			default: v = 5'd10;
		endcase
		return v;
	endfunction

	function automatic logic [63:0] smax_of(input logic [2:0] w);
		logic [63:0] v;
		case (w)
			W_8:     v = SMAX8;
			W_16:    v = SMAX16;
			W_32:    v = SMAX32;
			default: v = SMAX64;
		endcase
		return v;
	endfunction

	function automatic logic [63:0] umax_of(input logic [2:0] w);
		logic [63:0] v;
		case (w)
			W_8:     v = UMAX8;
			W_16:    v = UMAX16;
			W_32:    v = UMAX32;
			default: v = UMAX64;
		endcase
		return v;
	endfunction

endpackage

[rtl/integer_literal_parser.sv]
// integer_literal_parser: one character per transaction, strtoll/strtoull
// style integer literal parse with auto radix and optional range check.
// Depends on ilp_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------
//   in      | in_valid/in_stall  | char_code, width_code, is_signed
//   out     | out_valid/out_stall| value, status
//
// One character per cycle unless a zero byte waits; its parse step sets out_valid.
// Input register feeds the parse step, which writes the result register.
// Only a zero byte needs the result register free; other characters never
// wait on out_stall.
// Reset returns to the fresh phase (PH_FRESH) with both registers empty.

module integer_literal_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic [2:0]  width_code,
	input  logic        is_signed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value,
	output logic [1:0]  status
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic [2:0]  width_s1;
	logic        signed_s1;

	ilp_pkg::phase_t phase_q, phase_d;
	ilp_pkg::radix_t radix_q, radix_d;
	logic        neg_q, neg_d;
	logic [63:0] acc_q, acc_d;
	logic        ovf_q, ovf_d;
	logic        seen_q, seen_d;
	logic [2:0]  lwidth_q;
	logic        lsigned_q;

	logic        out_valid_q;
	logic [63:0] value_q;
	logic [1:0]  status_q;

	logic        step;
	logic        is_nul;
	logic [2:0]  eff_width;
	logic        eff_signed;
	logic [4:0]  dig;
	logic        is_ws;
	logic        add_en;
	ilp_pkg::radix_t add_radix;
	logic [67:0] prod;
	logic [67:0] sum;
	logic [63:0] limit;
	logic        ovf_now;

	logic [2:0]  chk_w;
	logic [63:0] res_value;
	logic [1:0]  res_status;
	logic [63:0] wrapped;

	assign is_nul     = (char_s1 == ilp_pkg::CH_NUL);
	assign step       = valid_s1 && (!is_nul || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !step;
	assign eff_width  = (phase_q == ilp_pkg::PH_FRESH) ? width_s1 : lwidth_q;
	assign eff_signed = (phase_q == ilp_pkg::PH_FRESH) ? signed_s1 : lsigned_q;
	assign dig        = ilp_pkg::digit_val(char_s1);
	assign is_ws      = (char_s1 == ilp_pkg::CH_SPACE) ||
		(char_s1 inside {[ilp_pkg::CH_TAB:ilp_pkg::CH_CR]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1   <= char_code;
			width_s1  <= width_code;
			signed_s1 <= is_signed;
		end
	end

	// next state: phase and digit decode
	always_comb begin
		phase_d   = phase_q;
		radix_d   = radix_q;
		neg_d     = neg_q;
		seen_d    = seen_q;
		add_en    = 1'b0;
		add_radix = radix_q;
		if (is_nul) begin
			phase_d = ilp_pkg::PH_FRESH;
			radix_d = ilp_pkg::RX_DEC;
			neg_d   = 1'b0;
			seen_d  = 1'b0;
		end else begin
			case (phase_q)
				ilp_pkg::PH_FRESH, ilp_pkg::PH_WS, ilp_pkg::PH_SIGN: begin
					if (phase_q != ilp_pkg::PH_SIGN && is_ws) begin
						phase_d = ilp_pkg::PH_WS;
					end else if (phase_q != ilp_pkg::PH_SIGN &&
						(char_s1 == ilp_pkg::CH_PLUS || char_s1 == ilp_pkg::CH_MINUS)) begin
						neg_d   = (char_s1 == ilp_pkg::CH_MINUS);
						phase_d = ilp_pkg::PH_SIGN;
					end else if (char_s1 == ilp_pkg::CH_0) begin
						seen_d  = 1'b1;
						phase_d = ilp_pkg::PH_ZERO;
					end else if (char_s1 inside {[ilp_pkg::CH_1:ilp_pkg::CH_9]}) begin
						radix_d   = ilp_pkg::RX_DEC;
						add_radix = ilp_pkg::RX_DEC;
						add_en    = 1'b1;
						phase_d   = ilp_pkg::PH_DIGITS;
					end else begin
						phase_d = ilp_pkg::PH_BAD;
					end
				end
				ilp_pkg::PH_ZERO: begin
					if (char_s1 == ilp_pkg::CH_LX || char_s1 == ilp_pkg::CH_UX) begin
						phase_d = ilp_pkg::PH_XPFX;
					end else if (dig < 5'd8) begin
						radix_d   = ilp_pkg::RX_OCT;
						add_radix = ilp_pkg::RX_OCT;
						add_en    = 1'b1;
						phase_d   = ilp_pkg::PH_DIGITS;
					end else begin
						phase_d = ilp_pkg::PH_BAD;
					end
				end
				ilp_pkg::PH_XPFX: begin
					if (dig < 5'd16) begin
						radix_d   = ilp_pkg::RX_HEX;
						add_radix = ilp_pkg::RX_HEX;
						add_en    = 1'b1;
						phase_d   = ilp_pkg::PH_DIGITS;
					end else begin
						phase_d = ilp_pkg::PH_BAD;
					end
				end
				ilp_pkg::PH_DIGITS: begin
					if (dig < ilp_pkg::radix_of(radix_q)) begin
						add_en = 1'b1;
					end else begin
						phase_d = ilp_pkg::PH_BAD;
					end
				end
				default: begin
					phase_d = ilp_pkg::PH_BAD;
				end
			endcase
			if (add_en) begin
				seen_d = 1'b1;
			end
		end
	end

	// acc*radix + digit, overflow when it passes the magnitude limit
	always_comb begin
		case (add_radix)
			ilp_pkg::RX_OCT: prod = {1'b0, acc_q, 3'b000};
			ilp_pkg::RX_HEX: prod = {acc_q, 4'b0000};
			default:         prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		endcase
		sum = prod + {64'd0, dig[3:0]};
		if (eff_signed) begin
			limit = neg_q ? (ilp_pkg::SMAX64 + 64'd1) : ilp_pkg::SMAX64;
		end else begin
			limit = ilp_pkg::UMAX64;
		end
		ovf_now = (sum > {4'b0000, limit});
		acc_d = acc_q;
		ovf_d = ovf_q;
		if (is_nul) begin
			acc_d = '0;
			ovf_d = 1'b0;
		end else if (add_en && !ovf_q) begin
			if (ovf_now) begin
				ovf_d = 1'b1;
			end else begin
				acc_d = sum[63:0];
			end
		end
	end

	// result for a zero byte
	always_comb begin
		chk_w      = (eff_width <= ilp_pkg::W_64) ? eff_width : ilp_pkg::W_NONE;
		wrapped    = 64'd0 - acc_q;
		res_value  = '0;
		res_status = ilp_pkg::ST_INVALID;
		if ((phase_q == ilp_pkg::PH_ZERO || phase_q == ilp_pkg::PH_DIGITS) && seen_q) begin
			if (ovf_q) begin
				res_status = ilp_pkg::ST_RANGE;
				if (eff_signed) begin
					res_value = neg_q ? (ilp_pkg::SMAX64 + 64'd1) : ilp_pkg::SMAX64;
				end else begin
					res_value = ilp_pkg::UMAX64;
				end
			end else begin
				res_value  = neg_q ? wrapped : acc_q;
				res_status = ilp_pkg::ST_OK;
				if (eff_signed) begin
					if (acc_q > (ilp_pkg::smax_of(chk_w) + {63'd0, neg_q})) begin
						res_status = ilp_pkg::ST_RANGE;
					end
				end else if (res_value > ilp_pkg::umax_of(chk_w)) begin
					res_status = ilp_pkg::ST_RANGE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ilp_pkg::PH_FRESH;
			radix_q   <= ilp_pkg::RX_DEC;
			neg_q     <= 1'b0;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			seen_q    <= 1'b0;
			lwidth_q  <= '0;
			lsigned_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			radix_q   <= radix_d;
			neg_q     <= neg_d;
			acc_q     <= acc_d;
			ovf_q     <= ovf_d;
			seen_q    <= seen_d;
			lwidth_q  <= is_nul ? 3'd0 : eff_width;
			lsigned_q <= is_nul ? 1'b0 : eff_signed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && is_nul) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_nul) begin
			value_q  <= res_value;
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ilp_pkg::ST_INVALID |-> value_q == 64'd0)
		else $error("invalid result with nonzero value");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && is_nul && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_nul_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_nul |=> phase_q == ilp_pkg::PH_FRESH && acc_q == 64'd0 && !ovf_q)
		else $error("state not cleared after end of literal");

	a_digits_seen: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ilp_pkg::PH_DIGITS |-> seen_q)
		else $error("digit phase without a digit");

	a_ovf_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && !is_nul && ovf_q |=> ovf_q && $stable(acc_q))
		else $error("accumulator changed after overflow");

endmodule

[test/literal_result_checker.sv]
// literal_result_checker: tracks the parser's character stream, predicts the
// value and status of every literal, and compares them with the result channel.
// Depends on ilp_pkg.

module literal_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic [2:0]  width_code,
	input  logic        is_signed,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] value,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0]      value;
		ilp_pkg::status_t status;
	} literal_result_t;

	literal_result_t literal_q[$];

	ilp_pkg::phase_t ph;
	logic        neg;
	ilp_pkg::radix_t rdx;
	logic [63:0] mag;
	logic        ovf;
	logic        seen;
	logic [2:0]  lw;
	logic        ls;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic clear_parse();
		ph = ilp_pkg::PH_FRESH;
		neg = 1'b0;
		rdx = ilp_pkg::RX_DEC;
		mag = '0;
		ovf = 1'b0;
		seen = 1'b0;
		lw = '0;
		ls = 1'b0;
	endtask

	function automatic int base_of(input ilp_pkg::radix_t r);
		case (r)
			ilp_pkg::RX_OCT:  return 8;
			ilp_pkg::RX_HEX:  return 16;
			default: return 10;
		endcase
	endfunction

	task automatic take_digit(input int d);
		logic [63:0] b;
		logic [63:0] lim;
		b = 64'(base_of(rdx));
		if (ls) begin
			lim = neg ? ilp_pkg::SMAX64 + 64'd1 : ilp_pkg::SMAX64;
		end else begin
			lim = ilp_pkg::UMAX64;
		end
		seen = 1'b1;
		if (!ovf) begin
			if (mag > (lim - 64'(d)) / b) begin
				ovf = 1'b1;
			end else begin
				mag = mag * b + 64'(d);
			end
		end
	endtask

	// one character; returns 1 and the literal's result on a zero byte
	task automatic parse_step(input logic [7:0] c, input logic [2:0] wc, input logic sg,
			output bit done, output literal_result_t r);
		int d;
		logic blank;
		logic as_digit;
		logic [63:0] smax;
		logic [63:0] umax;
		if (c >= ilp_pkg::CH_0 && c <= ilp_pkg::CH_9) begin
			d = int'(c - ilp_pkg::CH_0);
		end else if (c >= ilp_pkg::CH_LA && c <= ilp_pkg::CH_LF) begin
			d = int'(c - ilp_pkg::CH_LA) + 10;
		end else if (c >= ilp_pkg::CH_UA && c <= ilp_pkg::CH_UF) begin
			d = int'(c - ilp_pkg::CH_UA) + 10;
		end else begin
			d = 99;
		end
		blank = (c == ilp_pkg::CH_SPACE) || (c >= ilp_pkg::CH_TAB && c <= ilp_pkg::CH_CR);
		as_digit = 1'b0;
		done = 1'b0;
		r.value = '0;
		r.status = ilp_pkg::ST_INVALID;
		if (ph == ilp_pkg::PH_FRESH) begin
			lw = wc;
			ls = sg;
		end
		if (c == ilp_pkg::CH_NUL) begin
			done = 1'b1;
			if ((ph == ilp_pkg::PH_ZERO || ph == ilp_pkg::PH_DIGITS) && seen) begin
				if (ovf) begin
					r.status = ilp_pkg::ST_RANGE;
					if (ls) begin
						r.value = neg ? ilp_pkg::SMAX64 + 64'd1 : ilp_pkg::SMAX64;
					end else begin
						r.value = ilp_pkg::UMAX64;
					end
				end else begin
					case (lw)
						ilp_pkg::W_8: begin
							smax = ilp_pkg::SMAX8;
							umax = ilp_pkg::UMAX8;
						end
						ilp_pkg::W_16: begin
							smax = ilp_pkg::SMAX16;
							umax = ilp_pkg::UMAX16;
						end
						ilp_pkg::W_32: begin
							smax = ilp_pkg::SMAX32;
							umax = ilp_pkg::UMAX32;
						end
						default: begin
							smax = ilp_pkg::SMAX64;
							umax = ilp_pkg::UMAX64;
						end
					endcase
					r.value = neg ? 64'd0 - mag : mag;
					r.status = ilp_pkg::ST_OK;
					if (ls) begin
						if (mag > (neg ? smax + 64'd1 : smax)) begin
							r.status = ilp_pkg::ST_RANGE;
						end
					end else if (r.value > umax) begin
						r.status = ilp_pkg::ST_RANGE;
					end
				end
			end
			clear_parse();
		end else begin
			case (ph)
				ilp_pkg::PH_FRESH, ilp_pkg::PH_WS: begin
					if (blank) begin
						ph = ilp_pkg::PH_WS;
					end else if (c == ilp_pkg::CH_PLUS || c == ilp_pkg::CH_MINUS) begin
						neg = (c == ilp_pkg::CH_MINUS);
						ph = ilp_pkg::PH_SIGN;
					end else begin
						as_digit = 1'b1;
					end
				end
				ilp_pkg::PH_SIGN: begin
					as_digit = 1'b1;
				end
				ilp_pkg::PH_ZERO: begin
					if (c == ilp_pkg::CH_LX || c == ilp_pkg::CH_UX) begin
						ph = ilp_pkg::PH_XPFX;
					end else if (d < 8) begin
						rdx = ilp_pkg::RX_OCT;
						take_digit(d);
						ph = ilp_pkg::PH_DIGITS;
					end else begin
						ph = ilp_pkg::PH_BAD;
					end
				end
				ilp_pkg::PH_XPFX: begin
					if (d < 16) begin
						rdx = ilp_pkg::RX_HEX;
						take_digit(d);
						ph = ilp_pkg::PH_DIGITS;
					end else begin
						ph = ilp_pkg::PH_BAD;
					end
				end
				ilp_pkg::PH_DIGITS: begin
					if (d < base_of(rdx)) begin
						take_digit(d);
					end else begin
						ph = ilp_pkg::PH_BAD;
					end
				end
				default: begin
					ph = ilp_pkg::PH_BAD;
				end
			endcase
			if (as_digit) begin
				if (c == ilp_pkg::CH_0) begin
					seen = 1'b1;
					ph = ilp_pkg::PH_ZERO;
				end else if (c >= ilp_pkg::CH_1 && c <= ilp_pkg::CH_9) begin
					rdx = ilp_pkg::RX_DEC;
					take_digit(d);
					ph = ilp_pkg::PH_DIGITS;
				end else begin
					ph = ilp_pkg::PH_BAD;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit done;
		literal_result_t r;
		literal_result_t want;
		if (!arst_n) begin
			clear_parse();
			literal_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (literal_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result value=%h status=%0d",
						value, status));
				end else begin
					want = literal_q.pop_front();
					if (value !== want.value) begin
						report_mismatch($sformatf("value %h, expected %h", value, want.value));
					end
					if (status !== want.status) begin
						report_mismatch($sformatf("status %0d, expected %0d", status,
							want.status));
					end
				end
			end
			if (in_valid && !in_stall) begin
				parse_step(char_code, width_code, is_signed, done, r);
				if (done) begin
					literal_q.push_back(r);
				end
			end
			pending = literal_q.size();
		end
	end

endmodule

[test/tb.sv]
// tb: drives character streams into integer_literal_parser with random gaps
// and result stalls; literal_result_checker does the checking.
// Depends on ilp_pkg, integer_literal_parser and literal_result_checker.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;
	localparam int SQUEEZE_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic [2:0]  width_code;
	logic        is_signed;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] value;
	logic [1:0]  status;
	int          fail_count;
	int          pending;

	logic [7:0]  lit_q[$];
	bit          calm;
	bit          squeeze;
	int          chars_sent;
	int          idle;

	logic [63:0] bound_mag [0:20] = '{
		64'd0, 64'd1, 64'd127, 64'd128, 64'd129, 64'd255, 64'd256,
		64'd32767, 64'd32768, 64'd65535, 64'd65536,
		64'h7fff_ffff, 64'h8000_0000, 64'h8000_0001, 64'hffff_ffff, 64'h1_0000_0000,
		64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
		64'hffff_ffff_ffff_fffe, 64'hffff_ffff_ffff_ffff
	};

	integer_literal_parser uut (.*);

	literal_result_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// entered and left at a falling edge
	task automatic send_char(input logic [7:0] c, input logic [2:0] wc, input logic sg);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		width_code <= wc;
		is_signed <= sg;
		do @(posedge clk); while (in_stall);
		chars_sent++;
		@(negedge clk);
	endtask

	// range check code only counts on the first character; the rest get noise
	task automatic send_literal(input logic [2:0] wc, input logic sg);
		int i;
		for (i = 0; i < lit_q.size(); i++) begin
			send_char(lit_q[i], i == 0 ? wc : 3'($urandom), i == 0 ? sg : 1'($urandom));
		end
		send_char(ilp_pkg::CH_NUL, lit_q.size() == 0 ? wc : 3'($urandom),
			lit_q.size() == 0 ? sg : 1'($urandom));
		lit_q.delete();
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			lit_q.push_back(s[i]);
		end
	endtask

	task automatic push_digit(input int d);
		if (d < 10) begin
			lit_q.push_back(ilp_pkg::CH_0 + 8'(d));
		end else begin
			lit_q.push_back(($urandom_range(0, 1) ? ilp_pkg::CH_UA : ilp_pkg::CH_LA) +
				8'(d - 10));
		end
	endtask

	task automatic push_number(input logic [63:0] mag, input ilp_pkg::radix_t rx);
		int digs[$];
		int b;
		logic [63:0] m;
		b = rx == ilp_pkg::RX_OCT ? 8 : (rx == ilp_pkg::RX_HEX ? 16 : 10);
		m = mag;
		do begin
			digs.push_front(int'(m % 64'(b)));
			m = m / 64'(b);
		end while (m != 0);
		if (rx != ilp_pkg::RX_DEC) begin
			lit_q.push_back(ilp_pkg::CH_0);
		end
		if (rx == ilp_pkg::RX_HEX) begin
			lit_q.push_back($urandom_range(0, 1) ? ilp_pkg::CH_UX : ilp_pkg::CH_LX);
		end
		foreach (digs[i]) begin
			push_digit(digs[i]);
		end
		// extra digits can push the magnitude past 64 bits
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 3)) push_digit($urandom_range(0, b - 1));
		end
	endtask

	task automatic build_literal();
		int kind;
		int ws;
		int pick;
		logic [63:0] mag;
		kind = $urandom_range(0, 9);
		if (kind >= 8) begin
			repeat ($urandom_range(1, 6)) lit_q.push_back(8'($urandom_range(1, 255)));
		end else begin
			ws = $urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0;
			repeat (ws) begin
				pick = $urandom_range(0, 6);
				lit_q.push_back(pick == 0 ? ilp_pkg::CH_SPACE : ilp_pkg::CH_TAB + 8'(pick - 1));
			end
			case ($urandom_range(0, 2))
				1: lit_q.push_back(ilp_pkg::CH_PLUS);
				2: lit_q.push_back(ilp_pkg::CH_MINUS);
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: mag = 64'($urandom_range(0, 300));
				3, 4: mag = 64'($urandom_range(0, 65535));
				5, 6, 7: mag = bound_mag[$urandom_range(0, 20)] + 64'($urandom_range(0, 2)) - 64'd1;
				default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
			endcase
			push_number(mag, ilp_pkg::radix_t'($urandom_range(0, 2)));
			if (kind == 7) begin
				case ($urandom_range(0, 5))
					0: pick = $urandom_range(1, 255);
					1: pick = ilp_pkg::CH_SPACE;
					2: pick = ilp_pkg::CH_PLUS;
					3: pick = "8";
					4: pick = ilp_pkg::CH_LX;
					default: pick = "g";
				endcase
				lit_q.insert($urandom_range(0, lit_q.size()), 8'(pick));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		width_code = '0;
		is_signed = 1'b0;
		out_stall = 1'b0;
		calm = 1'b0;
		squeeze = 1'b0;
		chars_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_literal(ilp_pkg::W_NONE, 1'b1);
		push_text("  -");
		send_literal(ilp_pkg::W_NONE, 1'b1);
		push_text("0x");
		send_literal(ilp_pkg::W_NONE, 1'b0);
		push_text("08");
		send_literal(ilp_pkg::W_NONE, 1'b0);
		push_text("- 1");
		send_literal(ilp_pkg::W_NONE, 1'b1);
		push_text("1z");
		send_literal(ilp_pkg::W_NONE, 1'b0);
		push_text("0XaF");
		send_literal(ilp_pkg::W_8, 1'b0);
		push_text("-129");
		send_literal(ilp_pkg::W_8, 1'b1);
		push_text("-1");
		send_literal(ilp_pkg::W_32, 1'b0);

		// hold the result side off so the parser backs up into its input
		squeeze = 1'b1;
		calm = 1'b1;
		for (int i = 0; i < 12; i++) begin
			if (i % 2 == 1) begin
				lit_q.push_back(ilp_pkg::CH_9);
			end
			send_literal(3'($urandom), 1'($urandom));
		end

		while (chars_sent < 700) begin
			calm = ($urandom_range(0, 4) == 0);
			build_literal();
			send_literal(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		int hold;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (squeeze) begin
				squeeze = 1'b0;
				hold = SQUEEZE_CYCLES;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 7);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
			if (idle >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
